// File: rtl/core/mmbs_pkg.sv
package mmbs_pkg;

    // Bar scale
    localparam int BAR_W      = 8;
    localparam int BAR_STEP_W = $clog2(BAR_W);

    typedef logic [BAR_W-1:0] bar_t;

    // Item operations
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // Result status
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    // Register map
    localparam int   ADDR_W          = 3;
    localparam logic REG_BAR_WIDTH   = 1'b0;
    localparam bar_t BAR_WIDTH_RESET = 8'd70;

endpackage

// File: rtl/core/mmbs_store.sv
module mmbs_store #(
    parameter int DEPTH       = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int IDX_W       = 10
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [IDX_W-1:0]       waddr,
    input  logic [SAMPLE_BITS-1:0] wdata,
    input  logic [IDX_W-1:0]       raddr,
    output logic [SAMPLE_BITS-1:0] rdata
);

    logic [SAMPLE_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/mmbs_mul.sv
module mmbs_mul #(
    parameter int W = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [W-1:0]         multiplicand,
    input  mmbs_pkg::bar_t       multiplier,
    output logic                 done,
    output logic [W+mmbs_pkg::BAR_W-1:0] product
);

    import mmbs_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [BAR_STEP_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]          a_reg, a_next;
    bar_t                  b_reg, b_next;
    logic [W-1:0]          hi_reg, hi_next;
    bar_t                  lo_reg, lo_next;
    logic [W:0]            sum;

    // one multiplier bit a cycle, accumulator shifts right
    assign sum = {1'b0, hi_reg} + (b_reg[0] ? {1'b0, a_reg} : '0);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = multiplicand;
            b_next    = multiplier;
            hi_next   = '0;
            lo_next   = '0;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[W:1];
            lo_next  = {sum[0], lo_reg[BAR_W-1:1]};
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BAR_STEP_W'(BAR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// File: rtl/core/mmbs_div.sv
module mmbs_div #(
    parameter int W = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [W+mmbs_pkg::BAR_W-1:0]  dividend,
    input  logic [W-1:0]                  divisor,
    output logic                          done,
    output mmbs_pkg::bar_t                quotient
);

    import mmbs_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [BAR_STEP_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]          dsr_reg, dsr_next;
    logic [W-1:0]          rem_reg, rem_next;
    bar_t                  q_reg, q_next;
    logic [W:0]            trial;
    logic [W+1:0]          diff;
    logic                  fits;

    // restoring division; the upper dividend part is below the divisor,
    // so the quotient needs BAR_W bits only
    assign trial = {rem_reg, q_reg[BAR_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_reg};
    assign fits  = !diff[W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dsr_next  = divisor;
            rem_next  = dividend[W+BAR_W-1:BAR_W];
            q_next    = dividend[BAR_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[W-1:0] : trial[W-1:0];
            q_next   = {q_reg[BAR_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BAR_STEP_W'(BAR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: rtl/core/min_max_bar_scaler.sv
// Min-max bar scaler. A load item (op 0) is taken while busy stays low,
// so loads may follow back to back; a load into a full store is dropped.
// A draw item (op 1) raises busy for the store read in the fetch state, the
// bit-serial multiply by bar_width, the hand-over of the product, the
// bit-serial divide by max minus min and the registering of the quotient;
// done rises in the same cycle that busy falls.
// A draw of an index not loaded, or of a set whose samples are all equal,
// ends after the fetch state, with done rising as busy falls. The result
// sits on the result ports for exactly one cycle with done high and must be
// taken then: there is no way to hold it off.
// range_min and range_max follow the current set and are valid with done.
// Write bar_width only while busy is low and no result is pending.
module min_max_bar_scaler #(
    parameter int DEPTH       = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // item port
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic                          first,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [$clog2(DEPTH)-1:0]      index,
    // result port
    output logic                          done,
    output mmbs_pkg::bar_t                bar_length,
    output logic signed [SAMPLE_BITS-1:0] range_min,
    output logic signed [SAMPLE_BITS-1:0] range_max,
    output logic                          status,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mmbs_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import mmbs_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int W     = SAMPLE_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_MUL   = 2'd2;
    localparam logic [1:0] ST_DIV   = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic                  bad_reg, bad_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic signed [W-1:0]   min_reg, min_next;
    logic signed [W-1:0]   max_reg, max_next;
    bar_t                  width_reg, width_next;
    logic                  done_reg, done_next;
    bar_t                  len_reg, len_next;
    logic                  status_reg, status_next;

    logic                  accept;
    logic [CNT_W-1:0]      eff_count;
    logic                  store_we;
    logic [W-1:0]          rdata;
    logic [W:0]            off_full;
    logic [W:0]            span_full;
    logic [W-1:0]          span;
    logic                  mul_start, mul_done;
    logic [W+BAR_W-1:0]    product;
    logic                  div_start, div_done;
    bar_t                  quotient;
    logic                  cfg_wr;

    assign accept    = start && !busy;
    assign eff_count = first ? '0 : count_reg;
    assign store_we  = accept && (op == OP_LOAD) && (eff_count != CNT_W'(DEPTH));

    mmbs_store #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (eff_count[IDX_W-1:0]),
        .wdata (sample),
        .raddr (index),
        .rdata (rdata)
    );

    // both differences are non-negative and fit W bits unsigned
    assign off_full  = {rdata[W-1], rdata} - {min_reg[W-1], min_reg};
    assign span_full = {max_reg[W-1], max_reg} - {min_reg[W-1], min_reg};
    assign span      = span_full[W-1:0];

    mmbs_mul #(
        .W (W)
    ) u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (off_full[W-1:0]),
        .multiplier   (width_reg),
        .done         (mul_done),
        .product      (product)
    );

    mmbs_div #(
        .W (W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (span),
        .done     (div_done),
        .quotient (quotient)
    );

    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[ADDR_W-1] == REG_BAR_WIDTH);

    always_comb
    begin
        state_next  = state_reg;
        bad_next    = bad_reg;
        count_next  = count_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        width_next  = width_reg;
        done_next   = 1'b0;
        len_next    = len_reg;
        status_next = status_reg;
        mul_start   = 1'b0;
        div_start   = 1'b0;

        if (cfg_wr)
        begin
            width_next = pwdata[BAR_W-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == OP_LOAD))
                begin
                    if (store_we)
                    begin
                        count_next = eff_count + 1'b1;
                        if (eff_count == '0)
                        begin
                            min_next = sample;
                            max_next = sample;
                        end
                        else
                        begin
                            if (sample < min_reg)
                            begin
                                min_next = sample;
                            end
                            if (sample > max_reg)
                            begin
                                max_next = sample;
                            end
                        end
                    end
                end
                else if (accept)
                begin
                    bad_next   = CNT_W'(index) >= count_reg;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (bad_reg || (span == '0))
                begin
                    done_next   = 1'b1;
                    len_next    = '0;
                    status_next = bad_reg ? STATUS_BAD_INDEX : STATUS_OK;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    done_next   = 1'b1;
                    len_next    = quotient;
                    status_next = STATUS_OK;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bad_reg   <= 1'b0;
            count_reg <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            width_reg <= BAR_WIDTH_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bad_reg   <= bad_next;
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            width_reg <= width_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        status_reg <= status_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign bar_length = len_reg;
    assign range_min  = min_reg;
    assign range_max  = max_reg;
    assign status     = status_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1] == REG_BAR_WIDTH) ? {24'd0, width_reg} : 32'd0;

endmodule
